FILE: sv/c8core_pkg.sv
// -----------------------------------------------------------------------------
// c8core_pkg
// Shared types, codes and constants of the CHIP-8 core subset.
// -----------------------------------------------------------------------------
package c8core_pkg;

   localparam int ADDR_W    = 12;
   localparam int BYTE_W    = 8;
   localparam int INS_W     = 16;
   localparam int PIX_IDX_W = 11;
   localparam int ALU_W     = 13;
   localparam int NUM_V     = 16;

   localparam int MEM_BYTES_DEF     = 4096;
   localparam int SCREEN_WIDTH_DEF  = 64;
   localparam int SCREEN_HEIGHT_DEF = 32;

   localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
   localparam logic [INS_W-1:0]  CLS_WORD = 16'h00E0;
   localparam logic [3:0]        VF_IDX   = 4'hF;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_EXEC  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JUMP = 4'h1;
   localparam logic [3:0] OP_SETV = 4'h6;
   localparam logic [3:0] OP_ADDV = 4'h7;
   localparam logic [3:0] OP_SETI = 4'hA;
   localparam logic [3:0] OP_DRAW = 4'hD;

   typedef struct packed {
      logic [1:0]           func;
      logic [ADDR_W-1:0]    mem_addr;
      logic [BYTE_W-1:0]    mem_data;
      logic [PIX_IDX_W-1:0] pixel_index;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pc_now;
      logic [INS_W-1:0]  instruction;
      logic              collision;
      logic              pixel_value;
   } rsp_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             carry;
   } alu_rsp_type;

   typedef enum logic [1:0] {
      MOD_MEM,
      MOD_WIDTH,
      MOD_HEIGHT
   } mod_sel_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_WRITE,
      ST_FETCH_HI,
      ST_FETCH_LO_ADDR,
      ST_FETCH_LO,
      ST_DECODE,
      ST_EXEC,
      ST_DRAW_Y,
      ST_DRAW_ROWS,
      ST_DRAW_ADDR,
      ST_DRAW_READ,
      ST_DRAW_UPDATE,
      ST_PC_ADV,
      ST_PIX_READ,
      ST_PIX_BIT,
      ST_DONE
   } state_type;

endpackage

FILE: sv/chip8_core_subset_top.sv
// -----------------------------------------------------------------------------
// chip8_core_subset_top
// One transaction at a time; the next is accepted the cycle after the response
// registers, unless an earlier response is still stalled. Unused func codes and
// off-screen pixel reads go straight to the response. Memory addresses, draw
// columns and rows and the pixel index are reduced by repeated subtraction in
// the shared add/sub unit, so smaller sizes lengthen these transactions.
// After reset, a pass over every address zeroes program memory; req_stall is high.
// -----------------------------------------------------------------------------
module chip8_core_subset_top #(
   parameter int MEM_BYTES     = c8core_pkg::MEM_BYTES_DEF,
   parameter int SCREEN_WIDTH  = c8core_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = c8core_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  c8core_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output c8core_pkg::rsp_type rsp_data
);
   import c8core_pkg::*;

   localparam int AW     = $clog2(MEM_BYTES);
   localparam int CW     = $clog2(SCREEN_WIDTH);
   localparam int RW     = $clog2(SCREEN_HEIGHT);
   localparam int PIX    = SCREEN_WIDTH * SCREEN_HEIGHT;

   // sequencer state
   state_type             state_ff, state_in;
   state_type             ret_ff, ret_in;
   mod_sel_type           sel_ff, sel_in;
   logic [ADDR_W-1:0]     red_val_ff, red_val_in;
   logic [RW-1:0]         red_q_ff, red_q_in;
   req_type               req_ff, req_in;
   logic [INS_W-1:0]      ins_ff, ins_in;
   logic [ADDR_W-1:0]     pc_ff, pc_in;
   logic [ADDR_W-1:0]     i_ff, i_in;
   logic [BYTE_W-1:0]     v_ff [NUM_V];
   logic [BYTE_W-1:0]     v_in [NUM_V];
   logic [CW-1:0]         xm_ff, xm_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [3:0]            r_ff, r_in;
   logic                  hit_ff, hit_in;
   logic                  pval_ff, pval_in;
   logic [AW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // program memory
   logic [BYTE_W-1:0]     mem [MEM_BYTES];
   logic [BYTE_W-1:0]     mem_q_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [BYTE_W-1:0]     mem_wd;

   // screen, one row per entry
   logic [SCREEN_WIDTH-1:0]  scr [SCREEN_HEIGHT];
   logic [SCREEN_WIDTH-1:0]  scr_q_ff;
   logic                     scr_qv_ff;
   logic [SCREEN_HEIGHT-1:0] scr_vld_ff;
   logic                     scr_we, scr_re, scr_clr;
   logic [RW-1:0]            scr_wa, scr_ra;
   logic [SCREEN_WIDTH-1:0]  scr_wd;
   logic [SCREEN_WIDTH-1:0]  scr_old;
   logic [SCREEN_WIDTH-1:0]  draw_mask;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   logic [ALU_W-1:0]      mod_val;
   logic [3:0]            rf_ra;
   logic [BYTE_W-1:0]     rf_rd;
   logic                  req_accept;
   logic                  draw_hit;

   c8core_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign rf_ra   = (state_ff == ST_DRAW_Y) ? ins_ff[7:4] : ins_ff[11:8];
   assign rf_rd   = v_ff[rf_ra];
   assign scr_old = scr_qv_ff ? scr_q_ff : '0;
   assign draw_hit = |(scr_old & draw_mask);

   always_comb begin
      unique case (sel_ff)
         MOD_WIDTH:  mod_val = ALU_W'(SCREEN_WIDTH);
         MOD_HEIGHT: mod_val = ALU_W'(SCREEN_HEIGHT);
         default:    mod_val = ALU_W'(MEM_BYTES);
      endcase
   end

   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;
      unique case (state_ff)
         ST_REDUCE: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, red_val_ff};
            alu_req.b  = mod_val;
         end
         ST_FETCH_LO_ADDR: begin
            alu_req.a = {1'b0, pc_ff};
            alu_req.b = ALU_W'(1);
         end
         ST_EXEC: begin
            alu_req.a = ALU_W'(rf_rd);
            alu_req.b = ALU_W'(ins_ff[7:0]);
         end
         ST_DRAW_ADDR: begin
            alu_req.a = {1'b0, i_ff};
            alu_req.b = ALU_W'(r_ff);
         end
         ST_PC_ADV: begin
            alu_req.a = {1'b0, pc_ff};
            alu_req.b = ALU_W'(2);
         end
         default: begin
         end
      endcase
   end

   // sprite byte spread over the row with column wrap
   always_comb begin : mask_gen
      logic [CW:0] col;
      draw_mask = '0;
      for (int b = 0; b < 8; b++) begin
         col = {1'b0, xm_ff} + (CW+1)'(b);
         if (col >= (CW+1)'(SCREEN_WIDTH)) begin
            col = col - (CW+1)'(SCREEN_WIDTH);
         end
         if (mem_q_ff[3'(7 - b)]) begin
            draw_mask[col[CW-1:0]] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      sel_in       = sel_ff;
      red_val_in   = red_val_ff;
      red_q_in     = red_q_ff;
      req_in       = req_ff;
      ins_in       = ins_ff;
      pc_in        = pc_ff;
      i_in         = i_ff;
      v_in         = v_ff;
      xm_in        = xm_ff;
      row_in       = row_ff;
      r_in         = r_ff;
      hit_in       = hit_ff;
      pval_in      = pval_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = red_val_ff[AW-1:0];
      mem_wd       = req_ff.mem_data;
      mem_re       = 1'b0;
      mem_ra       = red_val_ff[AW-1:0];
      scr_we       = 1'b0;
      scr_wa       = row_ff;
      scr_wd       = scr_old ^ draw_mask;
      scr_re       = 1'b0;
      scr_ra       = row_ff;
      scr_clr      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               pval_in  = 1'b0;
               red_q_in = '0;
               unique case (req_data.func)
                  FUNC_WRITE: begin
                     red_val_in = req_data.mem_addr;
                     sel_in     = MOD_MEM;
                     ret_in     = ST_WRITE;
                     state_in   = ST_REDUCE;
                  end
                  FUNC_EXEC: begin
                     red_val_in = pc_ff;
                     sel_in     = MOD_MEM;
                     ret_in     = ST_FETCH_HI;
                     state_in   = ST_REDUCE;
                  end
                  FUNC_READ: begin
                     if (int'(req_data.pixel_index) < PIX) begin
                        red_val_in = ADDR_W'(req_data.pixel_index);
                        sel_in     = MOD_WIDTH;
                        ret_in     = ST_PIX_READ;
                        state_in   = ST_REDUCE;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            if (alu_rsp.carry) begin
               red_val_in = alu_rsp.sum[ADDR_W-1:0];
               red_q_in   = red_q_ff + RW'(1);
            end else begin
               state_in = ret_ff;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_FETCH_HI: begin
            mem_re   = 1'b1;
            state_in = ST_FETCH_LO_ADDR;
         end
         ST_FETCH_LO_ADDR: begin
            ins_in[15:8] = mem_q_ff;
            red_val_in   = alu_rsp.sum[ADDR_W-1:0];
            sel_in       = MOD_MEM;
            ret_in       = ST_FETCH_LO;
            state_in     = ST_REDUCE;
         end
         ST_FETCH_LO: begin
            mem_re   = 1'b1;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            ins_in[7:0] = mem_q_ff;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_PC_ADV;
            unique case (ins_ff[15:12])
               OP_SYS: begin
                  scr_clr = (ins_ff == CLS_WORD);
               end
               OP_JUMP: begin
                  pc_in    = ins_ff[ADDR_W-1:0];
                  state_in = ST_DONE;
               end
               OP_SETV: begin
                  v_in[ins_ff[11:8]] = ins_ff[7:0];
               end
               OP_ADDV: begin
                  v_in[ins_ff[11:8]] = alu_rsp.sum[BYTE_W-1:0];
               end
               OP_SETI: begin
                  i_in = ins_ff[ADDR_W-1:0];
               end
               OP_DRAW: begin
                  red_val_in = ADDR_W'(rf_rd);
                  red_q_in   = '0;
                  sel_in     = MOD_WIDTH;
                  ret_in     = ST_DRAW_Y;
                  hit_in     = 1'b0;
                  r_in       = '0;
                  state_in   = ST_REDUCE;
               end
               default: begin
               end
            endcase
         end
         ST_DRAW_Y: begin
            xm_in      = red_val_ff[CW-1:0];
            red_val_in = ADDR_W'(rf_rd);
            sel_in     = MOD_HEIGHT;
            ret_in     = ST_DRAW_ROWS;
            state_in   = ST_REDUCE;
         end
         ST_DRAW_ROWS: begin
            row_in = red_val_ff[RW-1:0];
            if (ins_ff[3:0] == 4'd0) begin
               v_in[VF_IDX] = '0;
               state_in     = ST_PC_ADV;
            end else begin
               state_in = ST_DRAW_ADDR;
            end
         end
         ST_DRAW_ADDR: begin
            red_val_in = alu_rsp.sum[ADDR_W-1:0];
            sel_in     = MOD_MEM;
            ret_in     = ST_DRAW_READ;
            state_in   = ST_REDUCE;
         end
         ST_DRAW_READ: begin
            mem_re   = 1'b1;
            scr_re   = 1'b1;
            state_in = ST_DRAW_UPDATE;
         end
         ST_DRAW_UPDATE: begin
            scr_we = 1'b1;
            hit_in = hit_ff | draw_hit;
            r_in   = r_ff + 4'd1;
            row_in = (row_ff == RW'(SCREEN_HEIGHT - 1)) ? '0 : row_ff + RW'(1);
            if (r_ff + 4'd1 == ins_ff[3:0]) begin
               v_in[VF_IDX] = {{(BYTE_W-1){1'b0}}, hit_ff | draw_hit};
               state_in     = ST_PC_ADV;
            end else begin
               state_in = ST_DRAW_ADDR;
            end
         end
         ST_PC_ADV: begin
            pc_in    = alu_rsp.sum[ADDR_W-1:0];
            state_in = ST_DONE;
         end
         ST_PIX_READ: begin
            scr_re   = 1'b1;
            scr_ra   = red_q_ff;
            state_in = ST_PIX_BIT;
         end
         ST_PIX_BIT: begin
            pval_in  = scr_old[red_val_ff[CW-1:0]];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pc_now      = pc_ff;
               rsp_data_in.instruction = (req_ff.func == FUNC_EXEC) ? ins_ff : '0;
               rsp_data_in.collision   = v_ff[VF_IDX][0];
               rsp_data_in.pixel_value = pval_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= PC_RESET;
         i_ff         <= '0;
         v_ff         <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         v_ff         <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      sel_ff      <= sel_in;
      red_val_ff  <= red_val_in;
      red_q_ff    <= red_q_in;
      req_ff      <= req_in;
      ins_ff      <= ins_in;
      xm_ff       <= xm_in;
      row_ff      <= row_in;
      r_ff        <= r_in;
      hit_ff      <= hit_in;
      pval_ff     <= pval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr[scr_wa] <= scr_wd;
      end
      if (scr_re) begin
         scr_q_ff  <= scr[scr_ra];
         scr_qv_ff <= scr_vld_ff[scr_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || scr_clr) begin
         scr_vld_ff <= '0;
      end else if (scr_we) begin
         scr_vld_ff[scr_wa] <= 1'b1;
      end
   end

   a_one_transaction : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("transaction accepted while busy");

   a_mem_range : assert property (@(posedge clock) disable iff (reset)
      mem_re |-> ({1'b0, mem_ra} < (AW+1)'(MEM_BYTES)))
      else $error("memory read beyond depth");

   a_scr_range : assert property (@(posedge clock) disable iff (reset)
      scr_we |-> ({1'b0, scr_wa} < (RW+1)'(SCREEN_HEIGHT)))
      else $error("screen row write beyond height");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule

FILE: sv/c8core_alu.sv
// -----------------------------------------------------------------------------
// c8core_alu
// Shared add/subtract unit; carry out of a subtract means a >= b.
// -----------------------------------------------------------------------------
module c8core_alu (
   input  c8core_pkg::alu_req_type req,
   output c8core_pkg::alu_rsp_type rsp
);
   import c8core_pkg::*;

   logic [ALU_W-1:0] b_eff;
   logic [ALU_W:0]   total;

   assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
   assign total = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (req.op == ALU_SUB)};

   assign rsp.sum   = total[ALU_W-1:0];
   assign rsp.carry = total[ALU_W];

endmodule

FILE: tb/tb_chip8_core_subset_top.sv
// -----------------------------------------------------------------------------
// tb_chip8_core_subset_top
// Self-checking bench for the CHIP-8 core subset. Short directed programs
// cover the idle paths, sprite wrap and collision, draw with zero rows, clear
// screen, a jump and a fetch across the top of memory. Random programs follow:
// each opcode is written at the current pc and then executed, mixed with
// sprite byte writes, pixel reads and noise. An in-bench emulator predicts
// every response, and a monitor compares each accepted response field by field.
// -----------------------------------------------------------------------------
module tb_chip8_core_subset_top;
   import c8core_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int PIXELS = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF;
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 10;
   int rsp_stall_pct = 45;
   int failures = 0;
   int results_checked = 0;
   int draws_seen = 0;
   int collisions_seen = 0;
   int lit_reads = 0;
   int quiet_cycles = 0;

   // emulator state
   logic [BYTE_W-1:0] img_mem [MEM_BYTES_DEF];
   bit                img_scr [PIXELS];
   logic [BYTE_W-1:0] img_v [NUM_V];
   logic [ADDR_W-1:0] img_i;
   logic [ADDR_W-1:0] cur_pc;

   rsp_type core_outcomes [$];
   rsp_type want;

   chip8_core_subset_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type emulate_item(input req_type item);
      rsp_type           outcome;
      logic [INS_W-1:0]  word;
      logic [ADDR_W-1:0] lo_addr;
      logic [ADDR_W-1:0] row_addr;
      logic [BYTE_W-1:0] row_bits;
      int                xs, ys, row, col, loc;
      bit                hit;
      outcome = '0;
      case (item.func)
         FUNC_WRITE: img_mem[item.mem_addr] = item.mem_data;
         FUNC_EXEC: begin
            lo_addr = cur_pc + ADDR_W'(1);
            word = {img_mem[cur_pc], img_mem[lo_addr]};
            outcome.instruction = word;
            case (word[15:12])
               OP_SYS: if (word == CLS_WORD) foreach (img_scr[i]) img_scr[i] = 1'b0;
               OP_SETV: img_v[word[11:8]] = word[7:0];
               OP_ADDV: img_v[word[11:8]] = img_v[word[11:8]] + word[7:0];
               OP_SETI: img_i = word[11:0];
               OP_DRAW: begin
                  xs = int'(img_v[word[11:8]]);
                  ys = int'(img_v[word[7:4]]);
                  hit = 1'b0;
                  row_addr = img_i;
                  for (row = 0; row < int'(word[3:0]); row++) begin
                     row_bits = img_mem[row_addr];
                     for (col = 0; col < 8; col++) begin
                        if (row_bits[7-col]) begin
                           loc = ((ys + row) % SCREEN_HEIGHT_DEF) * SCREEN_WIDTH_DEF
                                 + (xs + col) % SCREEN_WIDTH_DEF;
                           if (img_scr[loc]) hit = 1'b1;
                           img_scr[loc] = ~img_scr[loc];
                        end
                     end
                     row_addr = row_addr + ADDR_W'(1);
                  end
                  img_v[VF_IDX] = {7'd0, hit};
                  draws_seen++;
                  if (hit) collisions_seen++;
               end
               default: ;
            endcase
            if (word[15:12] == OP_JUMP) cur_pc = word[11:0];
            else cur_pc = cur_pc + 12'd2;
         end
         FUNC_READ: begin
            if (int'(item.pixel_index) < PIXELS)
               outcome.pixel_value = img_scr[item.pixel_index];
            if (outcome.pixel_value) lit_reads++;
         end
         default: ;
      endcase
      outcome.pc_now = cur_pc;
      outcome.collision = img_v[VF_IDX][0];
      return outcome;
   endfunction

   function automatic req_type random_item(input logic [1:0] func);
      req_type item;
      item.func = func;
      item.mem_addr = ADDR_W'($urandom_range(MEM_BYTES_DEF - 1));
      item.mem_data = BYTE_W'($urandom_range(255));
      item.pixel_index = PIX_IDX_W'($urandom_range(PIXELS - 1));
      return item;
   endfunction

   function automatic logic [INS_W-1:0] random_opcode_word();
      logic [INS_W-1:0] word;
      word = INS_W'($urandom);
      case ($urandom_range(19))
         0: word = CLS_WORD;
         1: word[15:12] = OP_SYS;
         2: word[15:12] = OP_JUMP;
         3, 4, 5, 6: word[15:12] = OP_SETV;
         7, 8, 9: word[15:12] = OP_ADDV;
         10, 11: begin
            word[15:12] = OP_SETI;
            if ($urandom_range(4) != 0) word[11:0] = ADDR_W'($urandom_range(63));
         end
         12, 13, 14, 15, 16, 17: word[15:12] = OP_DRAW;
         default: ;
      endcase
      return word;
   endfunction

   // expects to start at a falling edge, returns at one
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      core_outcomes.push_back(emulate_item(item));
      @(negedge clock);
   endtask

   task automatic put_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
      req_type item;
      item = random_item(FUNC_WRITE);
      item.mem_addr = addr;
      item.mem_data = data;
      send_item(item);
   endtask

   task automatic exec_here();
      send_item(random_item(FUNC_EXEC));
   endtask

   task automatic exec_word(input logic [INS_W-1:0] word);
      logic [ADDR_W-1:0] at;
      at = cur_pc;
      put_byte(at, word[15:8]);
      put_byte(at + ADDR_W'(1), word[7:0]);
      exec_here();
   endtask

   task automatic read_pixel(input logic [PIX_IDX_W-1:0] index);
      req_type item;
      item = random_item(FUNC_READ);
      item.pixel_index = index;
      send_item(item);
   endtask

   task automatic test_idle_paths();
      req_type item;
      item = random_item(FUNC_NONE);
      item.mem_addr = '1;
      item.mem_data = '1;
      item.pixel_index = '1;
      send_item(item);
      read_pixel('0);
      exec_here();
   endtask

   task automatic test_draw_wrap();
      exec_word({OP_SETI, 12'hFFF});
      exec_word({OP_SETV, VF_IDX, 8'h3F});
      put_byte(12'hFFF, 8'hFF);
      put_byte(12'h000, 8'h81);
      exec_word({OP_DRAW, VF_IDX, VF_IDX, 4'd2});
      exec_word({OP_DRAW, VF_IDX, VF_IDX, 4'd2});
      read_pixel(PIX_IDX_W'(PIXELS - 1));
   endtask

   task automatic test_jump_wrap();
      exec_word(CLS_WORD);
      exec_word({OP_DRAW, 4'h0, 4'h1, 4'h0});
      exec_word({OP_JUMP, 12'hFFF});
      exec_here();
      read_pixel(PIX_IDX_W'(PIXELS - 1));
   endtask

   task automatic test_random_program(input int count, input int sender_pct,
                                      input int receiver_pct);
      int sent;
      int pick;
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            exec_word(random_opcode_word());
            sent += 3;
         end else if (pick < 70) begin
            put_byte(img_i + ADDR_W'($urandom_range(15)), BYTE_W'($urandom));
            sent++;
         end else if (pick < 88) begin
            read_pixel(PIX_IDX_W'($urandom));
            sent++;
         end else if (pick < 93) begin
            exec_here();
            sent++;
         end else begin
            send_item(random_item($urandom_range(1) ? FUNC_NONE : FUNC_WRITE));
            sent++;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [INS_W-1:0] exp_val,
                                input logic [INS_W-1:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (core_outcomes.size() == 0) begin
            $display("%0t: response with no transaction pending: %p", $time, rsp_data);
            failures++;
         end else begin
            want = core_outcomes.pop_front();
            compare_field("pc_now", INS_W'(want.pc_now), INS_W'(rsp_data.pc_now));
            compare_field("instruction", want.instruction, rsp_data.instruction);
            compare_field("collision", INS_W'(want.collision),
                          INS_W'(rsp_data.collision));
            compare_field("pixel_value", INS_W'(want.pixel_value),
                          INS_W'(rsp_data.pixel_value));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      foreach (img_mem[i]) img_mem[i] = '0;
      foreach (img_scr[i]) img_scr[i] = 1'b0;
      foreach (img_v[i]) img_v[i] = '0;
      img_i = '0;
      cur_pc = PC_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_paths();
      test_draw_wrap();
      test_jump_wrap();
      test_random_program(480, 10, 45);
      test_random_program(480, 45, 10);
      test_random_program(490, 0, 0);

      req_valid <= 1'b0;
      while (core_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses from memory writes, executes and pixel reads.",
               results_checked);
      $display("Draws: %0d (%0d with collision), lit pixels read: %0d.",
               draws_seen, collisions_seen, lit_reads);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/c8core_pkg.sv
sv/c8core_alu.sv
sv/chip8_core_subset_top.sv
tb/tb_chip8_core_subset_top.sv
